### sv/tsp_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// tsp_distance_unit_macros.svh
// Assertion shorthands shared by the distance unit checkers.
// Both macros expect clk and rst to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef TSP_DISTANCE_UNIT_MACROS_SVH
`define TSP_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/tdu_pkg.sv
// ----------------------------------------------------------------------------
// tdu_pkg
// Widths, mode codes and the pipeline word type of the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tdu_pkg;

  localparam int FRAC_BITS  = 8;   // fraction bits of coordinates
  localparam int COORD_BITS = 31;  // significant coordinate bits
  localparam int FIELD_W    = 31;  // coordinate field width on the port
  localparam int FUNC_W     = 3;
  localparam int DIST_W     = 32;
  localparam int ATT_DIV    = 10;  // pseudo-Euclidean divisor

  localparam int DIFF_W  = COORD_BITS + 1;        // signed difference
  localparam int AX_W    = COORD_BITS;            // |difference|
  localparam int MSUM_W  = AX_W + 1;              // |dx| + |dy|
  localparam int SQ_W    = 2 * AX_W + 1;          // dx^2 + dy^2
  localparam int ROOT_W  = AX_W + 1;              // floor(sqrt(sq))
  localparam int PS_RAW  = (SQ_W - 2 * FRAC_BITS - 2) / 2;
  localparam int PS_W    = (PS_RAW > 0) ? PS_RAW : 1;  // pseudo root bits
  localparam int C10_W   = PS_W + 4;              // ATT_DIV * pseudo root
  localparam int TW      = SQ_W + 3;              // trial term width

  localparam int TDATA_W = ((4 * FIELD_W + 7) / 8) * 8;
  localparam int TUSER_W = FUNC_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ROUND     = 3'd0,
    FN_CEIL      = 3'd1,
    FN_PSEUDO    = 3'd2,
    FN_FIXED     = 3'd3,
    FN_MANHATTAN = 3'd4
  } func_t;

  // Word carried through the square-root stages.
  typedef struct packed {
    logic                valid;
    logic [FUNC_W-1:0]   func;
    logic [MSUM_W-1:0]   msum;   // Manhattan sum
    logic                nz;     // points differ
    logic [SQ_W-1:0]     rem;    // sq - q^2
    logic [ROOT_W-1:0]   q;      // root so far
    logic [SQ_W-1:0]     prem;   // sq - ATT_DIV * 2^(2F) * c^2
    logic [PS_W-1:0]     c;      // largest c with scaled c^2 below sq
    logic [C10_W-1:0]    c10;    // ATT_DIV * c
  } root_st_t;

endpackage

`default_nettype wire

### sv/tdu_front.sv
// ----------------------------------------------------------------------------
// tdu_front
// Four stages: coordinate differences, magnitudes, squares, squared sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tdu_front
  import tdu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [FIELD_W-1:0] first_x,
  input  wire logic [FIELD_W-1:0] first_y,
  input  wire logic [FIELD_W-1:0] second_x,
  input  wire logic [FIELD_W-1:0] second_y,
  output root_st_t                out
);

  // stage A
  logic                     va;
  logic [FUNC_W-1:0]        fa;
  logic signed [DIFF_W-1:0] dx, dy;
  // stage B
  logic                     vb;
  logic [FUNC_W-1:0]        fb;
  logic [AX_W-1:0]          ax, ay;
  // stage C
  logic                     vc;
  logic [FUNC_W-1:0]        fc;
  logic [2*AX_W-1:0]        sx, sy;
  logic [MSUM_W-1:0]        msum;
  logic                     nz;
  // stage D
  root_st_t                 sd;

  logic signed [DIFF_W-1:0] x1, y1, x2, y2;
  logic        [DIFF_W-1:0] dx_neg, dy_neg;

  assign x1 = DIFF_W'($signed(first_x[COORD_BITS-1:0]));
  assign y1 = DIFF_W'($signed(first_y[COORD_BITS-1:0]));
  assign x2 = DIFF_W'($signed(second_x[COORD_BITS-1:0]));
  assign y2 = DIFF_W'($signed(second_y[COORD_BITS-1:0]));

  assign dx_neg = DIFF_W'(0) - dx;
  assign dy_neg = DIFF_W'(0) - dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      va <= in_valid;
      fa <= func;
      dx <= x1 - x2;
      dy <= y1 - y2;

      vb <= va;
      fb <= fa;
      ax <= dx[DIFF_W-1] ? dx_neg[AX_W-1:0] : dx[AX_W-1:0];
      ay <= dy[DIFF_W-1] ? dy_neg[AX_W-1:0] : dy[AX_W-1:0];

      vc   <= vb;
      fc   <= fb;
      sx   <= ax * ax;
      sy   <= ay * ay;
      msum <= MSUM_W'(ax) + MSUM_W'(ay);
      nz   <= (ax != '0) || (ay != '0);

      sd.valid <= vc;
      sd.func  <= fc;
      sd.msum  <= msum;
      sd.nz    <= nz;
      sd.rem   <= SQ_W'(sx) + SQ_W'(sy);
      sd.q     <= '0;
      sd.prem  <= SQ_W'(sx) + SQ_W'(sy);
      sd.c     <= '0;
      sd.c10   <= '0;
    end
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      sd.valid <= 1'b0;
    end
  end

  assign out = sd;

endmodule

`default_nettype wire

### sv/tdu_root.sv
// ----------------------------------------------------------------------------
// tdu_root
// Restoring square root, one result bit per stage. The same stages also
// search the pseudo-Euclidean root on the scaled sum in their low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tdu_root
  import tdu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  root_st_t  in,
  output root_st_t  out
);

  function automatic root_st_t root_step(input root_st_t s, input int k);
    root_st_t        n;
    logic [TW-1:0]   mtrial;
    logic [TW-1:0]   ptrial;
    n = s;
    // (2q + 2^k) * 2^k; q has no bits at or below k, so OR is the add
    mtrial = ((TW'(s.q) << 1) | (TW'(1) << k)) << k;
    if (TW'(s.rem) >= mtrial) begin
      n.rem = s.rem - SQ_W'(mtrial);
      n.q   = s.q | (ROOT_W'(1) << k);
    end
    if (k < PS_W) begin
      // ATT_DIV * 2^(2F) * (2c + 2^k) * 2^k, strict compare
      ptrial = ((TW'(s.c10) << 1) + (TW'(ATT_DIV) << k)) << (k + 2 * FRAC_BITS);
      if (TW'(s.prem) > ptrial) begin
        n.prem = s.prem - SQ_W'(ptrial);
        n.c    = s.c | (PS_W'(1) << k);
        n.c10  = s.c10 + (C10_W'(ATT_DIV) << k);
      end
    end
    return n;
  endfunction

  root_st_t link [ROOT_W+1];

  assign link[0] = in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    root_st_t stg;
    always_ff @(posedge clk) begin
      if (adv) begin
        stg <= root_step(link[i], ROOT_W - 1 - i);
      end
      if (rst) begin
        stg.valid <= 1'b0;
      end
    end
    assign link[i+1] = stg;
  end

  assign out = link[ROOT_W];

endmodule

`default_nettype wire

### sv/tdu_select.sv
// ----------------------------------------------------------------------------
// tdu_select
// Mode selection and rounding from root and remainder; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdu_select
  import tdu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  root_st_t               in,
  output logic                   valid,
  output logic [DIST_W-1:0]      distance
);

  localparam int              HALF_IDX = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic [ROOT_W-1:0] LOW_MASK = ROOT_W'((64'(1) << FRAC_BITS) - 64'(1));

  logic [ROOT_W-1:0] r;
  logic              half;
  logic              exact;
  logic [DIST_W-1:0] distance_next;

  assign r = in.q >> FRAC_BITS;
  // round up when the fraction reaches one half; with no fraction bits,
  // when sq exceeds r^2 + r
  assign half  = (FRAC_BITS > 0) ? in.q[HALF_IDX] : (in.rem > SQ_W'(in.q));
  assign exact = ((in.q & LOW_MASK) == '0) && (in.rem == '0);

  always_comb begin
    unique case (in.func)
      FN_ROUND:     distance_next = DIST_W'(r) + DIST_W'(half);
      FN_CEIL:      distance_next = DIST_W'(r) + DIST_W'(!exact);
      FN_PSEUDO:    distance_next = in.nz ? DIST_W'(in.c) + DIST_W'(1) : '0;
      FN_FIXED:     distance_next = DIST_W'(in.q);
      FN_MANHATTAN: distance_next = DIST_W'(in.msum);
      default:      distance_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      valid    <= in.valid;
      distance <= distance_next;
    end
    if (rst) begin
      valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/tsp_distance_unit.sv
// ----------------------------------------------------------------------------
// tsp_distance_unit
// Point-pair distance for TSP instances: rounded, ceiling, pseudo-Euclidean,
// fixed-point Euclidean and Manhattan, exact from an integer square root.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields
//  --------+-----+-------------------------------------------------------
//  s_*     | in  | tuser: func; tdata: first_x, first_y, second_x, second_y
//  m_*     | out | tdata: distance
//
//  One word in and one word out per cycle while the output is not held.
//  Stages: 4 front stages (difference, magnitude, square, sum),
//  32 square-root stages (one result bit each), 1 output register.
//  rst is synchronous and clears only the valid bits of the stages.
//  The whole pipeline advances when the output register is empty or being
//  taken; a held output stalls every stage, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_distance_unit
  import tdu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // slave side
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // first_x[30:0], first_y[61:31],
                                             // second_x[92:62], second_y[123:93],
                                             // zero [127:124]
  input  wire logic [TUSER_W-1:0] s_tuser,   // func[2:0]
  // master side
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [DIST_W-1:0]       m_tdata    // distance[31:0]
);

  logic     adv;
  root_st_t front_word;
  root_st_t root_word;

  // global advance: output slot free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  tdu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .func     (s_tuser[FUNC_W-1:0]),
    .first_x  (s_tdata[FIELD_W-1:0]),
    .first_y  (s_tdata[2*FIELD_W-1:FIELD_W]),
    .second_x (s_tdata[3*FIELD_W-1:2*FIELD_W]),
    .second_y (s_tdata[4*FIELD_W-1:3*FIELD_W]),
    .out      (front_word)
  );

  tdu_root u_root (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .in  (front_word),
    .out (root_word)
  );

  tdu_select u_select (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in       (root_word),
    .valid    (m_tvalid),
    .distance (m_tdata)
  );

endmodule

`default_nettype wire

### sv/tdu_checker.sv
// ----------------------------------------------------------------------------
// tdu_checker
// Port-level checks of the distance unit flow control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tsp_distance_unit_macros.svh"

module tdu_checker
  import tdu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DIST_W-1:0] m_tdata
);

  `TDU_ASSERT_NOW(a_empty_takes, !m_tvalid, s_tready, "input blocked with empty output")
  `TDU_ASSERT_NOW(a_drain_takes, m_tready, s_tready, "input blocked while output drains")
  `TDU_ASSERT_NOW(a_full_blocks, m_tvalid && !m_tready, !s_tready, "input taken while output held")
  `TDU_ASSERT_NEXT(a_hold_word, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held word changed")

endmodule

bind tsp_distance_unit tdu_checker u_tdu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/tsp_distance_unit_tb.sv
// ----------------------------------------------------------------------------
// tsp_distance_unit_tb
// Streams point pairs through the distance unit and checks every output word
// against a behavioral distance calculation done at input acceptance. Runs a
// directed set (extremes, every mode, coincident points, rounding ties) and
// then random pairs under three source/sink throttling phases.
// ----------------------------------------------------------------------------
module tsp_distance_unit_tb;
  import tdu_pkg::*;

  localparam int C_MIN = -(1 << (FIELD_W - 1));
  localparam int C_MAX = (1 << (FIELD_W - 1)) - 1;
  localparam int ONE   = 1 << FRAC_BITS;   // 1.0 in coordinate units
  localparam int DRAIN_CYCLES = 40;        // a bit above the pipeline depth

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [TDATA_W-1:0] coords;
  } pair_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [TUSER_W-1:0] s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [DIST_W-1:0]  m_tdata;

  pair_word_t         pair_queue[$];     // words waiting to be sent
  logic [DIST_W-1:0]  dist_expected[$];  // distances in flight
  int                 send_idle = 0;     // percent of cycles the source holds off
  int                 recv_idle = 0;     // percent of cycles the sink stalls
  int                 fail_count = 0;

  tsp_distance_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] pair_distance(logic [FUNC_W-1:0] fn,
                                                      logic [TDATA_W-1:0] d);
    longint      x1, y1, x2, y2, dx, dy;
    logic [63:0] ax, ay, sq, q, r, h, b, den, t, c, res;
    x1 = $signed(d[FIELD_W-1:0]);
    y1 = $signed(d[2*FIELD_W-1:FIELD_W]);
    x2 = $signed(d[3*FIELD_W-1:2*FIELD_W]);
    y2 = $signed(d[4*FIELD_W-1:3*FIELD_W]);
    dx = x1 - x2;
    dy = y1 - y2;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;          // exact, in units of 2^-2F
    q  = floor_sqrt(sq);             // root in units of 2^-F
    r  = q >> FRAC_BITS;             // integer part
    case (fn)
      FN_ROUND: begin
        // round half up: bump when sqrt(sq) >= r + 0.5
        if (FRAC_BITS == 0) begin
          res = (r * (r + 1) < sq) ? r + 1 : r;
        end else begin
          h   = (r << FRAC_BITS) + (64'd1 << (FRAC_BITS - 1));
          res = (sq >= h * h) ? r + 1 : r;
        end
      end
      FN_CEIL: begin
        b   = r << FRAC_BITS;
        res = (b * b == sq) ? r : r + 1;
      end
      FN_PSEUDO: begin
        den = 64'(ATT_DIV) << (2 * FRAC_BITS);
        t   = sq / den + ((sq % den != 0) ? 64'd1 : 64'd0);
        c   = floor_sqrt(t);
        res = (c * c < t) ? c + 1 : c;
      end
      FN_FIXED:     res = q;
      FN_MANHATTAN: res = ax + ay;
      default:      res = '0;        // unused mode codes
    endcase
    return res[DIST_W-1:0];
  endfunction

  task automatic add_pair(input logic [FUNC_W-1:0] fn, input int x1, input int y1,
                          input int x2, input int y2);
    pair_word_t w;
    w.func   = fn;
    w.coords = TDATA_W'({y2[FIELD_W-1:0], x2[FIELD_W-1:0],
                         y1[FIELD_W-1:0], x1[FIELD_W-1:0]});
    pair_queue.push_back(w);
  endtask

  function automatic int edge_coord();
    case ($urandom_range(4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int grid_coord();
    // whole or half units, so exact squares and rounding ties show up often
    return (int'($urandom_range(400)) - 200) * ONE + ($urandom_range(1) ? ONE / 2 : 0);
  endfunction

  task automatic add_random(input int count);
    logic [FUNC_W-1:0] fn;
    int x1, y1, x2, y2;
    repeat (count) begin
      if ($urandom_range(15) < 14)
        fn = FUNC_W'($urandom_range(FN_MANHATTAN));
      else
        fn = FUNC_W'($urandom_range((1 << FUNC_W) - 1, FN_MANHATTAN + 1));
      case ($urandom_range(3))
        0: begin  // anywhere in the field range
          x1 = $urandom; y1 = $urandom; x2 = $urandom; y2 = $urandom;
        end
        1: begin  // close neighbours, wraps at the range edges
          x1 = $urandom; y1 = $urandom;
          x2 = x1 + int'($urandom_range(4095)) - 2048;
          y2 = y1 + int'($urandom_range(4095)) - 2048;
        end
        2: begin
          x1 = grid_coord(); y1 = grid_coord(); x2 = grid_coord();
          y2 = $urandom_range(3) ? grid_coord() : y1;
        end
        default: begin
          x1 = edge_coord(); y1 = edge_coord(); x2 = edge_coord(); y2 = edge_coord();
        end
      endcase
      add_pair(fn, x1, y1, x2, y2);
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // wait until every queued word is sent and every distance has come back
  task automatic drain();
    while (pair_queue.size() != 0 || s_tvalid || dist_expected.size() != 0)
      @(negedge clk);
  endtask

  // source: hold the word until taken, then load the next or go idle
  always @(posedge clk) begin
    pair_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        w = pair_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= w.coords;
        s_tuser  <= w.func;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink backpressure
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        dist_expected.push_back(pair_distance(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (dist_expected.size() == 0) begin
          note_failure($sformatf("unexpected word, distance %0d", m_tdata));
        end else begin
          want = dist_expected.pop_front();
          if (m_tdata !== want)
            note_failure($sformatf("distance expected %0d got %0d", want, m_tdata));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 29;
    recv_idle = 88;
    // every mode code, widest span
    for (int f = 0; f < (1 << FUNC_W); f++)
      add_pair(FUNC_W'(f), C_MIN, C_MIN, C_MAX, C_MAX);
    // coincident points
    add_pair(FN_ROUND,     C_MAX, C_MIN, C_MAX, C_MIN);
    add_pair(FN_PSEUDO,    C_MIN, C_MIN, C_MIN, C_MIN);
    add_pair(FN_FIXED,     0, 0, 0, 0);
    add_pair(FN_MANHATTAN, -1, C_MAX, -1, C_MAX);
    // opposite corners
    add_pair(FN_MANHATTAN, C_MAX, C_MIN, C_MIN, C_MAX);
    add_pair(FN_FIXED,     C_MAX, C_MIN, C_MIN, C_MAX);
    // 3-4-5 triangle, exact square
    add_pair(FN_ROUND,  0, 0, 3 * ONE, -4 * ONE);
    add_pair(FN_CEIL,   0, 0, 3 * ONE, -4 * ONE);
    add_pair(FN_PSEUDO, 0, 0, 3 * ONE, -4 * ONE);
    // rounding ties at x.5
    add_pair(FN_ROUND, 0, 0, ONE / 2, 0);
    add_pair(FN_ROUND, -ONE, 7, ONE / 2, 7);
    // one raw LSB apart
    add_pair(FN_CEIL,   0, 0, 1, 0);
    add_pair(FN_PSEUDO, 0, 0, 0, -1);
    add_pair(FN_FIXED,  5, 5, 4, 5);
    // pseudo-Euclidean with d^2/10 exact
    add_pair(FN_PSEUDO, 0, 0, 10 * ONE, 0);
    add_random(330);
    drain();

    send_idle = 88;
    recv_idle = 29;
    add_random(330);
    drain();

    send_idle = 0;
    recv_idle = 0;
    add_random(330);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tsp_distance_unit_tb passed");
    else
      $display("tsp_distance_unit_tb failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tsp_distance_unit_tb failed");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/tdu_pkg.sv
sv/tdu_front.sv
sv/tdu_root.sv
sv/tdu_select.sv
sv/tsp_distance_unit.sv
sv/tdu_checker.sv
tb/sv/tsp_distance_unit_tb.sv
